@@ rtl/rmze_pkg.sv @@
package rmze_pkg;

    localparam int TABLE_LEN = 24;
    localparam int GUARD_BITS = 8;
    localparam int CW = 30;
    localparam int ZW = 28;
    localparam logic signed [ZW-1:0] HALF_TURN = 28'sd11796480;
    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
    localparam int POS_LIMIT = 64000;
    localparam int ANG_LIMIT = 46080;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [ZW-1:0] t_angle;

    function automatic t_angle atan_entry(input int idx);
        t_angle tab [0:TABLE_LEN-1];
        tab = '{28'sd2949120, 28'sd1740967, 28'sd919879, 28'sd466945, 28'sd234379,
                28'sd117304, 28'sd58666, 28'sd29335, 28'sd14668, 28'sd7334,
                28'sd3667, 28'sd1833, 28'sd917, 28'sd458, 28'sd229, 28'sd115,
                28'sd57, 28'sd29, 28'sd14, 28'sd7, 28'sd4, 28'sd2, 28'sd1, 28'sd0};
        return tab[idx];
    endfunction

endpackage

@@ rtl/rotation_matrix_to_zyx_euler_core.sv @@
// Throughput: one pose per cycle; busy is always low, since every stage advances each cycle
// and the receiver cannot stall, so a result is shown for one cycle only.
// The first CORDIC bank (cy) and the second bank (pitch, roll, yaw) set the depth.
// Reset clears the valid chain and the gimbal threshold register; payload is not reset.
module rotation_matrix_to_zyx_euler_core #(
    parameter int FRACTION_BITS = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [16:0]         i_cfg_data,
    input  logic signed [19:0]  i_pos_x,
    input  logic signed [19:0]  i_pos_y,
    input  logic signed [19:0]  i_pos_z,
    input  logic signed [17:0]  i_r00,
    input  logic signed [17:0]  i_r10,
    input  logic signed [17:0]  i_r20,
    input  logic signed [17:0]  i_r21,
    input  logic signed [17:0]  i_r22,
    input  logic signed [17:0]  i_r01,
    input  logic signed [17:0]  i_r11,
    output logic                o_valid,
    output logic signed [16:0]  o_x_mm,
    output logic signed [16:0]  o_y_mm,
    output logic signed [16:0]  o_z_mm,
    output logic signed [16:0]  o_roll_deg,
    output logic signed [16:0]  o_pitch_deg,
    output logic signed [16:0]  o_yaw_deg,
    output logic                o_gimbal_lock
);

    localparam int NS = (CORDIC_STEPS < rmze_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                              : rmze_pkg::TABLE_LEN;
    // Stage layout: s0 input register, s1..sNS cy CORDIC, then gain multiply,
    // round and compare, branch select and pre-rotation, NS angle CORDIC stages,
    // and the output rounding stage.
    localparam int TOT = 2 * NS + 4;
    // Delay line length that brings r_mm to the output register.
    localparam int MMD = 2 * NS + 1;

    // The three scaled positions travel through a plain delay line.
    logic signed [19:0] r_pos [0:2];
    logic signed [16:0] r_mm [0:2];
    logic signed [16:0] r_mmd [0:MMD-1][0:2];

    assign busy = 1'b0;
    assign o_cfg_ready = 1'b1;

    logic [16:0] r_thresh;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thresh <= i_cfg_data;
        end
    end

    logic acc;
    assign acc = start && !busy;

    // Valid chain.
    logic [TOT:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[TOT-1:0], acc};
        end
    end

    // ---------------- Stage 0: capture and widen by the guard bits.
    rmze_pkg::t_coord r0_m [0:6];
    always_ff @(posedge i_clk) begin
        r_pos[0] <= i_pos_x;
        r_pos[1] <= i_pos_y;
        r_pos[2] <= i_pos_z;
        r0_m[0] <= rmze_pkg::CW'(i_r00) <<< rmze_pkg::GUARD_BITS;
        r0_m[1] <= rmze_pkg::CW'(i_r10) <<< rmze_pkg::GUARD_BITS;
        r0_m[2] <= rmze_pkg::CW'(i_r20) <<< rmze_pkg::GUARD_BITS;
        r0_m[3] <= rmze_pkg::CW'(i_r21) <<< rmze_pkg::GUARD_BITS;
        r0_m[4] <= rmze_pkg::CW'(i_r22) <<< rmze_pkg::GUARD_BITS;
        r0_m[5] <= rmze_pkg::CW'(i_r01) <<< rmze_pkg::GUARD_BITS;
        r0_m[6] <= rmze_pkg::CW'(i_r11) <<< rmze_pkg::GUARD_BITS;
    end

    // Position scaling: p*16000 rounded half up at FRACTION_BITS, saturated.
    // One multiply stage then a round/saturate stage, which is registered in r_mm.
    logic signed [35:0] r_prod [0:2];
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_prod[k] <= 36'(r_pos[k]) * 36'sd16000;
        end
    end
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            logic signed [35:0] v;
            v = (r_prod[k] + (36'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
            if (v > 36'sd64000) begin
                r_mm[k] <= 17'sd64000;
            end else if (v < -36'sd64000) begin
                r_mm[k] <= -17'sd64000;
            end else begin
                r_mm[k] <= v[16:0];
            end
        end
    end
    // r_mm is registered after r_prod, aligned with r_vld[2]; delay it to the output.
    always_ff @(posedge i_clk) begin
        r_mmd[0] <= r_mm;
        for (int s = 1; s < MMD; s++) begin
            r_mmd[s] <= r_mmd[s-1];
        end
    end

    // ---------------- First bank: cy = |(|r00|, r10)|. |r00| >= 0 needs no pre-rotation.
    // Matrix operands ride along the bank.
    rmze_pkg::t_coord a_x [0:NS];
    rmze_pkg::t_coord a_y [0:NS];
    rmze_pkg::t_coord a_m [0:NS][0:6];
    always_comb begin
        a_x[0] = r0_m[0][rmze_pkg::CW-1] ? -r0_m[0] : r0_m[0];
        a_y[0] = r0_m[1];
        a_m[0] = r0_m;
    end
    for (genvar i = 0; i < NS; i++) begin : g_cy
        rmze_pkg::t_coord r_x, r_y;
        rmze_pkg::t_coord r_m [0:6];
        always_ff @(posedge i_clk) begin
            if (a_y[i] >= 0) begin
                r_x <= a_x[i] + (a_y[i] >>> i);
                r_y <= a_y[i] - (a_x[i] >>> i);
            end else begin
                r_x <= a_x[i] - (a_y[i] >>> i);
                r_y <= a_y[i] + (a_x[i] >>> i);
            end
            r_m <= a_m[i];
        end
        assign a_x[i+1] = r_x;
        assign a_y[i+1] = r_y;
        assign a_m[i+1] = r_m;
    end

    // Zero magnitude when both operands are zero: CORDIC keeps x = 0 there anyway.
    // ---------------- Gain correction.
    logic [59:0] r_cyp;
    rmze_pkg::t_coord r_gm [0:6];
    always_ff @(posedge i_clk) begin
        r_cyp <= 60'(a_x[NS][rmze_pkg::CW-1:0]) * 60'(rmze_pkg::INV_GAIN_Q30);
        r_gm <= a_m[NS];
    end

    // ---------------- Round cy and compare with the threshold.
    rmze_pkg::t_coord r_cy;
    logic r_lock;
    rmze_pkg::t_coord r_lm [0:6];
    always_ff @(posedge i_clk) begin
        logic [29:0] cyv;
        logic [29:0] cyq;
        cyv = r_cyp[59:30];
        cyq = (cyv + 30'd128) >> rmze_pkg::GUARD_BITS;
        r_cy <= $signed(cyv);
        r_lock <= !(cyq > 30'(r_thresh));
        r_lm <= r_gm;
    end

    // ---------------- Branch select and the left-half pre-rotation for three lanes.
    // Lane 0 pitch, lane 1 roll, lane 2 yaw.
    rmze_pkg::t_coord b_x [0:NS][0:2];
    rmze_pkg::t_coord b_y [0:NS][0:2];
    rmze_pkg::t_angle b_z [0:NS][0:2];
    logic b_zero [0:NS][0:2];
    logic b_lock [0:NS];
    always_ff @(posedge i_clk) begin
        rmze_pkg::t_coord ox [0:2];
        rmze_pkg::t_coord oy [0:2];
        ox[0] = r_cy;
        oy[0] = -r_lm[2];
        if (!r_lock) begin
            ox[1] = r_lm[4];
            oy[1] = r_lm[3];
        end else begin
            ox[1] = r_lm[6];
            oy[1] = r_lm[2][rmze_pkg::CW-1] ? r_lm[5] : -r_lm[5];
        end
        ox[2] = r_lm[0];
        oy[2] = r_lm[1];
        for (int k = 0; k < 3; k++) begin
            b_zero[0][k] <= (ox[k] == 0) && (oy[k] == 0);
            if (ox[k] < 0) begin
                b_x[0][k] <= -ox[k];
                b_y[0][k] <= -oy[k];
                b_z[0][k] <= (oy[k] >= 0) ? rmze_pkg::HALF_TURN : -rmze_pkg::HALF_TURN;
            end else begin
                b_x[0][k] <= ox[k];
                b_y[0][k] <= oy[k];
                b_z[0][k] <= '0;
            end
        end
        b_lock[0] <= r_lock;
    end
    for (genvar i = 0; i < NS; i++) begin : g_ang
        always_ff @(posedge i_clk) begin
            for (int k = 0; k < 3; k++) begin
                if (b_y[i][k] >= 0) begin
                    b_x[i+1][k] <= b_x[i][k] + (b_y[i][k] >>> i);
                    b_y[i+1][k] <= b_y[i][k] - (b_x[i][k] >>> i);
                    b_z[i+1][k] <= b_z[i][k] + rmze_pkg::atan_entry(i);
                end else begin
                    b_x[i+1][k] <= b_x[i][k] - (b_y[i][k] >>> i);
                    b_y[i+1][k] <= b_y[i][k] + (b_x[i][k] >>> i);
                    b_z[i+1][k] <= b_z[i][k] - rmze_pkg::atan_entry(i);
                end
            end
            b_zero[i+1] <= b_zero[i];
            b_lock[i+1] <= b_lock[i];
        end
    end

    // ---------------- Output: round the angle to 1/256 degree and saturate.
    function automatic logic signed [16:0] ang_out(input rmze_pkg::t_angle z, input logic zr);
        rmze_pkg::t_angle v;
        v = (z + 28'sd128) >>> 8;
        if (zr) begin
            return '0;
        end else if (v > 28'(rmze_pkg::ANG_LIMIT)) begin
            return 17'(rmze_pkg::ANG_LIMIT);
        end else if (v < -28'(rmze_pkg::ANG_LIMIT)) begin
            return -17'(rmze_pkg::ANG_LIMIT);
        end
        return v[16:0];
    endfunction

    always_ff @(posedge i_clk) begin
        o_x_mm <= r_mmd[MMD-1][0];
        o_y_mm <= r_mmd[MMD-1][1];
        o_z_mm <= r_mmd[MMD-1][2];
        o_pitch_deg <= ang_out(b_z[NS][0], b_zero[NS][0]);
        o_roll_deg <= ang_out(b_z[NS][1], b_zero[NS][1]);
        o_yaw_deg <= b_lock[NS] ? 17'sd0 : ang_out(b_z[NS][2], b_zero[NS][2]);
        o_gimbal_lock <= b_lock[NS];
    end

    assign o_valid = r_vld[TOT];

    // Pipeline depth: input 1, cy bank NS, gain 1, compare 1, select 1, bank NS, output 1.
    // A pose accepted now leaves once it has passed through all of these stages.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> ##(TOT+1) o_valid) else $error("result missing after pipeline latency");
    a_yaw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_gimbal_lock) |-> (o_yaw_deg == 17'sd0))
        else $error("yaw not zero under gimbal lock");
    a_ang: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_deg <= 17'sd46080 && o_pitch_deg >= -17'sd46080))
        else $error("pitch out of range");

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = 16;
    localparam int FRAC = 16;
    localparam int PIPE_DEPTH = 2 * STEPS + 8;
    localparam int STALL_LIMIT = 1000;
    localparam longint TURN_HALF = 180 * 65536;
    localparam longint INV_K_Q30 = 652032874;
    localparam longint POS_SAT = 64000;
    localparam longint ANG_SAT = 46080;
    localparam int REPORT_MAX = 10;

    // One pose on the input ports.
    typedef struct {
        logic signed [19:0] px, py, pz;
        logic signed [17:0] r00, r10, r20, r21, r22, r01, r11;
    } t_pose;

    // One set of outputs: millimetre position, three angles and the lock flag.
    typedef struct packed {
        logic signed [16:0] x_mm, y_mm, z_mm;
        logic signed [16:0] roll, pitch, yaw;
        logic               lock;
    } t_euler;

    // Keeps its own copy of the threshold register and the results of poses in flight,
    // works out the Euler angles of each accepted pose and compares them with
    // what comes out of the pipeline, oldest first.
    class euler_scoreboard;
        t_euler     in_flight[$];
        logic [16:0] threshold = 0;
        int         mismatches = 0;

        static function longint sat(longint v, longint lim);
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        // Vectoring CORDIC: the angle of (x, y) in 2^-16 degree, plus the
        // unscaled magnitude.
        static function longint cordic_atan2(longint y, longint x, output longint mag);
            longint z, dx, dy;
            z = 0;
            mag = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0) begin
                z = (y >= 0) ? TURN_HALF : -TURN_HALF;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < STEPS; i++) begin
                dx = x >>> i;
                dy = y >>> i;
                if (y >= 0) begin
                    x += dy;
                    y -= dx;
                    z += longint'(rmze_pkg::atan_entry(i));
                end else begin
                    x -= dy;
                    y += dx;
                    z -= longint'(rmze_pkg::atan_entry(i));
                end
            end
            mag = x;
            return z;
        endfunction

        static function longint to_deg256(longint z);
            return sat((z + 128) >>> 8, ANG_SAT);
        endfunction

        static function longint to_mm16(longint p);
            return sat((p * 16000 + (longint'(1) << (FRAC - 1))) >>> FRAC, POS_SAT);
        endfunction

        function void note_pose(t_pose p);
            longint g, r00, r10, r20, r21, r22, r01, r11;
            longint mag, cy, cyq, pitch, roll, yaw, unused;
            longint unsigned prod;
            t_euler e;
            g = 256;
            r00 = longint'(p.r00) * g;
            r10 = longint'(p.r10) * g;
            r20 = longint'(p.r20) * g;
            r21 = longint'(p.r21) * g;
            r22 = longint'(p.r22) * g;
            r01 = longint'(p.r01) * g;
            r11 = longint'(p.r11) * g;
            void'(cordic_atan2(r10, (r00 < 0) ? -r00 : r00, mag));
            prod = longint'(mag) * INV_K_Q30;
            cy = longint'(prod >> 30);
            cyq = (cy + g / 2) >>> 8;
            e.lock = !(cyq > longint'({15'd0, threshold}));
            pitch = cordic_atan2(-r20, cy, unused);
            if (!e.lock) begin
                roll = cordic_atan2(r21, r22, unused);
                yaw = cordic_atan2(r10, r00, unused);
            end else begin
                // Gimbal lock: yaw is pinned to zero and roll comes from the
                // first two entries of column one, sign-flipped by r20.
                roll = cordic_atan2((r20 < 0) ? r01 : -r01, r11, unused);
                yaw = 0;
            end
            e.x_mm = 17'(to_mm16(longint'(p.px)));
            e.y_mm = 17'(to_mm16(longint'(p.py)));
            e.z_mm = 17'(to_mm16(longint'(p.pz)));
            e.roll = 17'(to_deg256(roll));
            e.pitch = 17'(to_deg256(pitch));
            e.yaw = 17'(to_deg256(yaw));
            in_flight.push_back(e);
        endfunction

        function void check_result(t_euler got);
            t_euler want;
            if (in_flight.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("Unexpected result: x=%0d y=%0d z=%0d roll=%0d pitch=%0d yaw=%0d",
                             got.x_mm, got.y_mm, got.z_mm, got.roll, got.pitch, got.yaw);
                return;
            end
            want = in_flight.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("Mismatch at %0t: expected x=%0d y=%0d z=%0d roll=%0d pitch=%0d",
                             $realtime, want.x_mm, want.y_mm, want.z_mm, want.roll,
                             want.pitch);
                    $display("    expected yaw=%0d lock=%0b", want.yaw, want.lock);
                    $display("    got x=%0d y=%0d z=%0d roll=%0d pitch=%0d yaw=%0d lock=%0b",
                             got.x_mm, got.y_mm, got.z_mm, got.roll, got.pitch, got.yaw,
                             got.lock);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [16:0] i_cfg_data = '0;
    logic signed [19:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic signed [17:0] i_r00 = '0, i_r10 = '0, i_r20 = '0, i_r21 = '0;
    logic signed [17:0] i_r22 = '0, i_r01 = '0, i_r11 = '0;
    logic o_valid;
    logic signed [16:0] o_x_mm, o_y_mm, o_z_mm, o_roll_deg, o_pitch_deg, o_yaw_deg;
    logic o_gimbal_lock;

    euler_scoreboard board = new();
    int stall_cycles = 0;

    always #1 i_clk = ~i_clk;

    rotation_matrix_to_zyx_euler_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_r00(i_r00), .i_r10(i_r10), .i_r20(i_r20), .i_r21(i_r21), .i_r22(i_r22),
        .i_r01(i_r01), .i_r11(i_r11),
        .o_valid(o_valid), .o_x_mm(o_x_mm), .o_y_mm(o_y_mm), .o_z_mm(o_z_mm),
        .o_roll_deg(o_roll_deg), .o_pitch_deg(o_pitch_deg), .o_yaw_deg(o_yaw_deg),
        .o_gimbal_lock(o_gimbal_lock)
    );

    // The monitor samples at the rising edge, before any nonblocking update of
    // that edge lands, so it sees exactly what the block sees. A pose transfer
    // is noted, a result is checked, and the watchdog counts edges with no transfer of any kind.
    always @(posedge i_clk) begin
        t_pose p;
        t_euler r;
        if (i_rst_n) begin
            if (start && !busy) begin
                p.px = i_pos_x; p.py = i_pos_y; p.pz = i_pos_z;
                p.r00 = i_r00; p.r10 = i_r10; p.r20 = i_r20; p.r21 = i_r21;
                p.r22 = i_r22; p.r01 = i_r01; p.r11 = i_r11;
                board.note_pose(p);
            end
            if (o_valid) begin
                r.x_mm = o_x_mm; r.y_mm = o_y_mm; r.z_mm = o_z_mm;
                r.roll = o_roll_deg; r.pitch = o_pitch_deg; r.yaw = o_yaw_deg;
                r.lock = o_gimbal_lock;
                board.check_result(r);
            end
            if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Presents one pose and holds it until the transfer happens. Start is left
    // high so that back-to-back poses keep it asserted without a glitch.
    task automatic send_pose(t_pose p);
        start <= 1'b1;
        i_pos_x <= p.px; i_pos_y <= p.py; i_pos_z <= p.pz;
        i_r00 <= p.r00; i_r10 <= p.r10; i_r20 <= p.r20; i_r21 <= p.r21;
        i_r22 <= p.r22; i_r01 <= p.r01; i_r11 <= p.r11;
        do @(posedge i_clk); while (busy);
    endtask

    // Now and then, when allowed, drops start for an idle burst of random length.
    task automatic maybe_idle(bit allowed);
        if (allowed && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // Lets the pipeline drain completely, then writes the threshold register.
    task automatic write_threshold(logic [16:0] value);
        start <= 1'b0;
        @(posedge i_clk);
        while (board.in_flight.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.threshold = value;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [17:0] to_q16(real v);
        return 18'($rtoi(v * 65536.0));
    endfunction

    // A proper Z-Y-X rotation with random angles; pitch is pushed to +-90
    // degrees now and then so that the lock branch gets real matrices.
    function automatic t_pose rotation_pose();
        t_pose p;
        real d2r, a, b, c, sa, ca, sb, cb, sc, cc;
        d2r = 3.14159265358979323846 / 180.0;
        a = ($urandom_range(0, 72000) / 100.0 - 360.0) * d2r;
        c = ($urandom_range(0, 72000) / 100.0 - 360.0) * d2r;
        case ($urandom_range(0, 5))
            0: b = 90.0 * d2r;
            1: b = -90.0 * d2r;
            2: b = (($urandom_range(0, 200) / 100.0) + 88.0) * d2r;
            default: b = ($urandom_range(0, 18000) / 100.0 - 90.0) * d2r;
        endcase
        sa = $sin(a); ca = $cos(a); sb = $sin(b); cb = $cos(b);
        sc = $sin(c); cc = $cos(c);
        p.r00 = to_q16(cb * cc);
        p.r10 = to_q16(cb * sc);
        p.r20 = to_q16(-sb);
        p.r21 = to_q16(cb * sa);
        p.r22 = to_q16(cb * ca);
        p.r01 = to_q16(cc * sb * sa - sc * ca);
        p.r11 = to_q16(sc * sb * sa + cc * ca);
        p.px = 20'($signed($urandom_range(0, 524288)) - 262144);
        p.py = 20'($signed($urandom_range(0, 524288)) - 262144);
        p.pz = 20'($signed($urandom_range(0, 524288)) - 262144);
        return p;
    endfunction

    // Arbitrary bit patterns over the full width of every field.
    function automatic t_pose noise_pose();
        t_pose p;
        p.px = 20'($urandom); p.py = 20'($urandom); p.pz = 20'($urandom);
        p.r00 = 18'($urandom); p.r10 = 18'($urandom); p.r20 = 18'($urandom);
        p.r21 = 18'($urandom); p.r22 = 18'($urandom); p.r01 = 18'($urandom);
        p.r11 = 18'($urandom);
        return p;
    endfunction

    function automatic t_pose make_pose(int px, int py, int pz, int r00, int r10,
                                        int r20, int r21, int r22, int r01, int r11);
        t_pose p;
        p.px = 20'(px); p.py = 20'(py); p.pz = 20'(pz);
        p.r00 = 18'(r00); p.r10 = 18'(r10); p.r20 = 18'(r20); p.r21 = 18'(r21);
        p.r22 = 18'(r22); p.r01 = 18'(r01); p.r11 = 18'(r11);
        return p;
    endfunction

    initial begin
        logic [16:0] settings [5];
        t_pose directed[$];
        bit last_phase;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed poses: identity, zero matrix, both pitch singularities with
        // either sign of r20, left-half vectors, rounding and saturation edges.
        directed.push_back(make_pose(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 65536));
        directed.push_back(make_pose(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_pose(1, -1, 2, 0, 0, -65536, 0, 0, 46341, 46341));
        directed.push_back(make_pose(-2, 3, -3, 0, 0, 65536, 0, 0, 46341, -46341));
        directed.push_back(make_pose(0, 0, 0, 0, 0, -65536, 0, 0, 0, 0));
        directed.push_back(make_pose(262144, -262144, 262144, -65536, 0, 0, 0, -65536,
                                     0, -65536));
        directed.push_back(make_pose(4, 5, -4, -65536, -1, 0, -1, -65536, 0, 65536));
        directed.push_back(make_pose(524287, 524287, 524287, 131071, 131071, 131071,
                                     131071, 131071, 131071, 131071));
        directed.push_back(make_pose(-524288, -524288, -524288, -131072, -131072,
                                     -131072, -131072, -131072, -131072, -131072));
        directed.push_back(make_pose(2, -2, 6, 0, 65536, 0, 65536, 0, -65536, 0));
        directed.push_back(make_pose(-6, 7, 0, 0, -65536, 0, -65536, 0, 65536, 0));
        directed.push_back(make_pose(0, 0, 0, -65536, 0, 1, 0, 65536, 0, -65536));
        directed.push_back(make_pose(100, 200, 300, 1, 0, -1, 1, 0, -1, 0));
        directed.push_back(make_pose(-100, -200, -300, 46341, 46341, 0, 46341,
                                     -46341, -46341, 46341));

        // Phases of threshold settings: reset value, 65536, a tiny one, a random one
        // and a middle one. Each phase sends the directed set, then 100 random poses.
        settings[0] = 17'd0;
        settings[1] = 17'd65536;
        settings[2] = 17'd1;
        settings[3] = 17'($urandom_range(1, 65535));
        settings[4] = 17'd32768;
        for (int ph = 0; ph < 5; ph++) begin
            last_phase = (ph == 4);
            write_threshold(settings[ph]);
            foreach (directed[k]) begin
                send_pose(directed[k]);
                maybe_idle(!last_phase);
            end
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(0, 4) == 0)
                    send_pose(noise_pose());
                else
                    send_pose(rotation_pose());
                maybe_idle(!last_phase);
            end
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (board.in_flight.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);

        if (board.mismatches == 0 && board.in_flight.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/rmze_pkg.sv
rtl/rotation_matrix_to_zyx_euler_core.sv
tb/tb_top.sv
